// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the replay stamp table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PRST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PRST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/prst_pkg.sv -----
// Package with the types, constants and codes of the replay stamp table.
package prst_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int MAC_W     = 48;
  localparam int STAMP_W   = 64;
  localparam int REG_W     = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int JIT_SHIFT = 8;

  // Command codes of an input word; the fourth code yields a result word with no flag set.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_VERIFY = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_FRAME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_JITTER = 1'd1;

  // Requests from the sequencer to the slot store.
  typedef struct packed {
    logic [IDX_W-1:0]   mac_raddr;
    logic [IDX_W-1:0]   stamp_raddr;
    logic               add_en;
    logic               upd_en;
    logic               clr_en;
    logic [IDX_W-1:0]   waddr;
    logic [MAC_W-1:0]   wr_mac;
    logic [STAMP_W-1:0] wr_stamp;
  } store_req_t;

endpackage

// ----- rtl/prst_stream_if.sv -----
// Valid/ready stream interfaces for the command words and result words.
interface prst_in_if
  import prst_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [MAC_W-1:0]   peer_mac;
  logic [STAMP_W-1:0] packet_stamp;
  logic [STAMP_W-1:0] now_stamp;
  logic               use_jitter;

  modport source (
    output valid, command, peer_mac, packet_stamp, now_stamp, use_jitter,
    input  ready
  );
  modport sink (
    input  valid, command, peer_mac, packet_stamp, now_stamp, use_jitter,
    output ready
  );
endinterface

interface prst_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic peer_found;
  logic table_full;

  modport source (
    output valid, accepted, peer_found, table_full,
    input  ready
  );
  modport sink (
    input  valid, accepted, peer_found, table_full,
    output ready
  );
endinterface

// ----- rtl/prst_sub_unit.sv -----
// Shared 64-bit subtractor with borrow, used for every stamp compare.
module prst_sub_unit
  import prst_pkg::*;
(
  input  logic [STAMP_W-1:0] a_i,
  input  logic [STAMP_W-1:0] b_i,
  output logic [STAMP_W-1:0] diff_o,
  output logic               borrow_o
);

  logic [STAMP_W:0] full_diff;

  // The borrow is set exactly when a is below b as unsigned numbers.
  assign full_diff = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o    = full_diff[STAMP_W-1:0];
  assign borrow_o  = full_diff[STAMP_W];

endmodule

// ----- rtl/prst_slot_store.sv -----
// Slot store: MAC and stamp memories with one read port each, plus valid bits.
module prst_slot_store
  import prst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  store_req_t               req_i,
  output logic [MAC_W-1:0]         mac_rdata_o,
  output logic [STAMP_W-1:0]       stamp_rdata_o,
  output logic [TABLE_ENTRIES-1:0] valid_o
);

  logic [MAC_W-1:0]         mac_mem   [TABLE_ENTRIES];
  logic [STAMP_W-1:0]       stamp_mem [TABLE_ENTRIES];
  logic [MAC_W-1:0]         mac_rdata_q;
  logic [STAMP_W-1:0]       stamp_rdata_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.add_en) begin
      mac_mem[req_i.waddr] <= req_i.wr_mac;
    end
    if (req_i.add_en || req_i.upd_en) begin
      stamp_mem[req_i.waddr] <= req_i.wr_stamp;
    end
    mac_rdata_q   <= mac_mem[req_i.mac_raddr];
    stamp_rdata_q <= stamp_mem[req_i.stamp_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (req_i.add_en) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        valid_q[req_i.waddr] <= 1'b0;
      end
    end
  end

  assign mac_rdata_o   = mac_rdata_q;
  assign stamp_rdata_o = stamp_rdata_q;
  assign valid_o       = valid_q;

endmodule

// ----- rtl/peer_replay_stamp_table.sv -----
// Top level of the peer replay stamp table: sequencer, configuration and ports.
//
// This block keeps a table of TABLE_ENTRIES peers keyed by 48-bit MAC address,
// each with the stamp of its last valid packet, and serves one command word at
// a time: add a peer (its stamp starts at now minus stamp_frame), remove a
// peer, or verify a packet stamp against the time window and, for a known
// peer, against the stored stamp with optional jitter allowance. Every command
// word yields exactly one result word. The input is ready only while the
// sequencer is idle. A command first scans the MAC memory through its single
// read port, one slot per cycle, stopping at the first valid match; a miss
// scans all slots. After the scan, the stamp checks run as a short chain of
// steps on one shared 64-bit subtractor. The finished result sits in an
// output register, so the next command word is taken while it waits to be
// read; a command that finishes while the previous result word is still unread
// waits for it to be taken.
// The user must write the configuration registers through cfg_we_i only
// while no command is in flight; the block itself does not enforce this.
// The valid bits clear at reset; no clearing pass is needed.
module peer_replay_stamp_table
  import prst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  prst_in_if.sink              in_i,
  prst_out_if.source           out_o
);

  // Sequencer states: scan the table, decide by command, then step through
  // the subtractor operations that the command needs.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ADD_WR,
    ST_WIN_DIFF,
    ST_WIN_MAG,
    ST_WIN_CMP,
    ST_FR_DIFF,
    ST_FR_NEG,
    ST_FR_JIT,
    ST_FR_CMPU,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [REG_W-1:0] frame_q, frame_d;
  logic [REG_W-1:0] jitter_q, jitter_d;

  // Latched command word.
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [MAC_W-1:0]   mac_q, mac_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [STAMP_W-1:0] now_q, now_d;
  logic               jit_q, jit_d;

  // Scan pipeline: issue stage addresses the MAC memory, compare stage checks
  // the registered read data in the following cycle.
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic             issue_done_q, issue_done_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             free_vld_q, free_vld_d;
  logic [IDX_W-1:0] free_q, free_d;

  // Working value of the subtractor chain.
  logic [STAMP_W-1:0] t_q, t_d;

  // Result being built and the output register.
  logic res_acc_q, res_acc_d;
  logic res_found_q, res_found_d;
  logic res_full_q, res_full_d;
  logic out_valid_q, out_valid_d;
  logic out_acc_q, out_acc_d;
  logic out_found_q, out_found_d;
  logic out_full_q, out_full_d;

  // Slot store and subtractor connections.
  store_req_t               store_req;
  logic [MAC_W-1:0]         mac_rdata;
  logic [STAMP_W-1:0]       stamp_rdata;
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [STAMP_W-1:0]       alu_a, alu_b, alu_diff;
  logic                     alu_borrow;
  logic [STAMP_W-1:0]       jit_val;
  logic [STAMP_W-1:0]       frame_ext;
  logic                     mac_match;

  prst_slot_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (store_req),
    .mac_rdata_o   (mac_rdata),
    .stamp_rdata_o (stamp_rdata),
    .valid_o       (slot_valid)
  );

  prst_sub_unit u_sub (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign frame_ext = {{(STAMP_W-REG_W){1'b0}}, frame_q};

  // Jitter allowance: scaled up by 256 when bit 0 of the packet stamp is set.
  always_comb begin
    jit_val = '0;
    if (jit_q) begin
      if (stamp_q[0]) begin
        jit_val = {{(STAMP_W-REG_W-JIT_SHIFT){1'b0}}, jitter_q, {JIT_SHIFT{1'b0}}};
      end else begin
        jit_val = {{(STAMP_W-REG_W){1'b0}}, jitter_q};
      end
    end
  end

  assign mac_match = cmp_vld_q && slot_valid[cmp_idx_q] && (mac_rdata == mac_q);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.accepted   = out_acc_q;
  assign out_o.peer_found = out_found_q;
  assign out_o.table_full = out_full_q;

  always_comb begin
    state_d      = state_q;
    frame_d      = frame_q;
    jitter_d     = jitter_q;
    cmd_d        = cmd_q;
    mac_d        = mac_q;
    stamp_d      = stamp_q;
    now_d        = now_q;
    jit_d        = jit_q;
    scan_idx_d   = scan_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    free_vld_d   = free_vld_q;
    free_d       = free_q;
    t_d          = t_q;
    res_acc_d    = res_acc_q;
    res_found_d  = res_found_q;
    res_full_d   = res_full_q;
    out_valid_d  = out_valid_q;
    out_acc_d    = out_acc_q;
    out_found_d  = out_found_q;
    out_full_d   = out_full_q;

    alu_a = '0;
    alu_b = '0;

    store_req             = '0;
    store_req.mac_raddr   = scan_idx_q;
    store_req.stamp_raddr = slot_q;
    store_req.waddr       = slot_q;
    store_req.wr_mac      = mac_q;
    store_req.wr_stamp    = stamp_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STAMP_FRAME:  frame_d  = cfg_data_i;
        CFG_STAMP_JITTER: jitter_d = cfg_data_i;
        default: ;
      endcase
    end

    // A waiting result leaves when it is taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d        = in_i.command;
          mac_d        = in_i.peer_mac;
          stamp_d      = in_i.packet_stamp;
          now_d        = in_i.now_stamp;
          jit_d        = in_i.use_jitter;
          scan_idx_d   = '0;
          issue_done_d = 1'b0;
          cmp_vld_d    = 1'b0;
          hit_d        = 1'b0;
          free_vld_d   = 1'b0;
          res_acc_d    = 1'b0;
          res_found_d  = 1'b0;
          res_full_d   = 1'b0;
          case (in_i.command)
            CMD_ADD, CMD_REMOVE, CMD_VERIFY: state_d = ST_SCAN;
            default:                         state_d = ST_FINISH;
          endcase
        end
      end

      ST_SCAN: begin
        if (!issue_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_idx_q;
          if (!slot_valid[scan_idx_q] && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_d     = scan_idx_q;
          end
          if (scan_idx_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (mac_match) begin
          hit_d     = 1'b1;
          slot_d    = cmp_idx_q;
          cmp_vld_d = 1'b0;
          state_d   = ST_DECIDE;
        end else if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
          cmp_vld_d = 1'b0;
          state_d   = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        case (cmd_q)
          CMD_ADD: begin
            if (hit_q) begin
              res_found_d = 1'b1;
              state_d     = ST_FINISH;
            end else if (!free_vld_q) begin
              res_full_d = 1'b1;
              state_d    = ST_FINISH;
            end else begin
              state_d = ST_ADD_WR;
            end
          end
          CMD_REMOVE: begin
            if (hit_q) begin
              store_req.clr_en = 1'b1;
              res_acc_d        = 1'b1;
              res_found_d      = 1'b1;
            end
            state_d = ST_FINISH;
          end
          CMD_VERIFY: begin
            res_found_d = hit_q;
            state_d     = ST_WIN_DIFF;
          end
          default: state_d = ST_FINISH;
        endcase
      end

      ST_ADD_WR: begin
        alu_a              = now_q;
        alu_b              = frame_ext;
        store_req.add_en   = 1'b1;
        store_req.waddr    = free_q;
        store_req.wr_stamp = alu_diff;
        res_acc_d          = 1'b1;
        state_d            = ST_FINISH;
      end

      ST_WIN_DIFF: begin
        alu_a   = stamp_q;
        alu_b   = now_q;
        t_d     = alu_diff;
        state_d = ST_WIN_MAG;
      end

      ST_WIN_MAG: begin
        // Magnitude of the signed difference: negate when the sign bit is set.
        if (t_q[STAMP_W-1]) begin
          alu_a = '0;
          alu_b = t_q;
        end else begin
          alu_a = t_q;
          alu_b = '0;
        end
        t_d     = alu_diff;
        state_d = ST_WIN_CMP;
      end

      ST_WIN_CMP: begin
        alu_a = t_q;
        alu_b = frame_ext;
        if (alu_borrow) begin
          if (hit_q) begin
            state_d = ST_FR_DIFF;
          end else begin
            res_acc_d = 1'b1;
            state_d   = ST_FINISH;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FR_DIFF: begin
        alu_a = stamp_q;
        alu_b = stamp_rdata;
        t_d   = alu_diff;
        if ((alu_diff != '0) && !alu_diff[STAMP_W-1]) begin
          state_d = ST_FR_CMPU;
        end else begin
          state_d = ST_FR_NEG;
        end
      end

      ST_FR_NEG: begin
        alu_a   = '0;
        alu_b   = t_q;
        t_d     = alu_diff;
        state_d = ST_FR_JIT;
      end

      ST_FR_JIT: begin
        // Fresh when the allowance exceeds how far the stamp went back.
        alu_a = t_q;
        alu_b = jit_val;
        if (alu_borrow) begin
          state_d = ST_FR_CMPU;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FR_CMPU: begin
        // The stored stamp only moves forward.
        alu_a = stamp_rdata;
        alu_b = stamp_q;
        if (alu_borrow) begin
          store_req.upd_en = 1'b1;
        end
        res_acc_d = 1'b1;
        state_d   = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = res_acc_q;
          out_found_d = res_found_q;
          out_full_d  = res_full_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frame_q      <= '0;
      jitter_q     <= '0;
      scan_idx_q   <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_acc_q    <= 1'b0;
      out_found_q  <= 1'b0;
      out_full_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      frame_q      <= frame_d;
      jitter_q     <= jitter_d;
      scan_idx_q   <= scan_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_vld_q   <= free_vld_d;
      out_valid_q  <= out_valid_d;
      out_acc_q    <= out_acc_d;
      out_found_q  <= out_found_d;
      out_full_q   <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    mac_q       <= mac_d;
    stamp_q     <= stamp_d;
    now_q       <= now_d;
    jit_q       <= jit_d;
    cmp_idx_q   <= cmp_idx_d;
    slot_q      <= slot_d;
    free_q      <= free_d;
    t_q         <= t_d;
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
  end

endmodule

// ----- rtl/prst_checker.sv -----
// Port checker for the replay stamp table and its bind to the top level.
`include "assert_macros.svh"

module prst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_accepted_i,
  input logic out_peer_found_i,
  input logic out_table_full_i
);

  // A result word stays offered until it is taken.
  `PRST_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result word dropped")

  // A full table is only reported for an absent peer whose add failed.
  `PRST_ASSERT(a_full_excl, out_valid_i && out_table_full_i |-> !out_accepted_i && !out_peer_found_i, "table full with accept or found")

  // One command word at a time: the input closes right after a word is taken.
  `PRST_ASSERT(a_one_cmd, in_valid_i && in_ready_i |=> !in_ready_i, "second word taken while busy")

  // No result word is offered during reset.
  `PRST_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_i, "result word during reset")

endmodule

bind peer_replay_stamp_table prst_checker u_prst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_accepted_i   (out_o.accepted),
  .out_peer_found_i (out_o.peer_found),
  .out_table_full_i (out_o.table_full)
);
